// ===== hdl/udp_frame_header_parser_core_defines.svh =====
// ----------------------------------------------------------------------------
// udp frame header parser assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef UDP_FRAME_HEADER_PARSER_CORE_DEFINES_SVH
`define UDP_FRAME_HEADER_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define UFHP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ufhp port check failed");

// next-cycle implication
`define UFHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ufhp port check failed");

`endif

// ===== hdl/ufhp_pkg.sv =====
// ----------------------------------------------------------------------------
// ufhp_pkg
// shared types and constants of the udp frame header parser
// ----------------------------------------------------------------------------
`default_nettype none

package ufhp_pkg;

  localparam int POSITION_BITS_DEF = 17;
  localparam int HEADER_BYTES      = 10;
  localparam int QUEUE_DEPTH       = 4;
  localparam int CFG_ADDR_W        = 2;
  localparam int CFG_DATA_W        = 8;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_VERSION_CODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DATA_TYPE_CODE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ACK_TYPE_CODE  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BIG_ENDIAN     = 2'd3;

  // status codes
  localparam logic [2:0] STATUS_OK           = 3'd0;
  localparam logic [2:0] STATUS_TOO_SHORT    = 3'd1;
  localparam logic [2:0] STATUS_BAD_VERSION  = 3'd2;
  localparam logic [2:0] STATUS_BAD_TYPE     = 3'd3;
  localparam logic [2:0] STATUS_LEN_MISMATCH = 3'd4;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // header byte positions
  localparam logic [3:0] POS_VERSION  = 4'd0;
  localparam logic [3:0] POS_TYPE     = 4'd1;
  localparam logic [3:0] POS_ID_FIRST = 4'd2;
  localparam logic [3:0] POS_ID_LAST  = 4'd5;
  localparam logic [3:0] POS_FCOUNT   = 4'd6;
  localparam logic [3:0] POS_FINDEX   = 4'd7;
  localparam logic [3:0] POS_LEN_LAST = 4'd9;

  // result tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [2:0]  status;
    logic [15:0] content_length;
    logic [7:0]  frame_index;
    logic [7:0]  frame_count;
    logic [31:0] packet_id;
    logic        is_ack;
    logic [7:0]  frame_version;
    logic [7:0]  payload_byte;
  } out_data_t;

  localparam int OUT_TDATA_W = $bits(out_data_t);

  // one queued work entry: an optional payload beat and an optional summary
  typedef struct packed {
    logic        has_pay;
    logic        has_sum;
    logic [7:0]  pay_byte;
    logic [7:0]  frame_version;
    logic        is_ack;
    logic [31:0] packet_id;
    logic [7:0]  frame_count;
    logic [7:0]  frame_index;
    logic [15:0] content_length;
    logic [2:0]  status;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/ufhp_front.sv =====
// ----------------------------------------------------------------------------
// ufhp_front
// accepts datagram bytes, captures header fields and queues work entries
// ----------------------------------------------------------------------------
`default_nettype none

module ufhp_front #(
  parameter int POSITION_BITS = ufhp_pkg::POSITION_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ufhp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [ufhp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  input  wire logic [7:0]                       in_tdata,
  input  wire logic                             in_tlast,
  output      logic                             push,
  output      ufhp_pkg::entry_t                 push_entry
);

  import ufhp_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam int CW = (PW > 17) ? PW : 17;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
  localparam logic [PW-1:0] HDR_LEN = PW'(HEADER_BYTES);

  logic [7:0]    version_code_r, data_type_code_r, ack_type_code_r;
  logic          big_endian_r;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    ver_r, ver_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [31:0]   id_r, id_nxt;
  logic [7:0]    fc_r, fc_nxt;
  logic [7:0]    fi_r, fi_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [2:0]    err_r, err_nxt;

  logic          accept;
  logic [PW-1:0] total;
  logic [1:0]    id_lane;
  logic [2:0]    status;

  assign accept  = in_tvalid && in_tready;
  assign total   = (pos_r == POS_MAX) ? POS_MAX : pos_r + PW'(1);
  assign id_lane = pos_r[1:0] - 2'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_code_r   <= 8'd0;
      data_type_code_r <= 8'd0;
      ack_type_code_r  <= 8'd1;
      big_endian_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_VERSION_CODE:   version_code_r   <= cfg_wdata;
        REG_DATA_TYPE_CODE: data_type_code_r <= cfg_wdata;
        REG_ACK_TYPE_CODE:  ack_type_code_r  <= cfg_wdata;
        REG_BIG_ENDIAN:     big_endian_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // header capture
  always_comb begin
    ver_nxt  = ver_r;
    type_nxt = type_r;
    id_nxt   = id_r;
    fc_nxt   = fc_r;
    fi_nxt   = fi_r;
    len_nxt  = len_r;
    err_nxt  = err_r;
    if (accept && (pos_r < HDR_LEN)) begin
      case (pos_r[3:0]) inside
        POS_VERSION: begin
          ver_nxt = in_tdata;
          if (in_tdata != version_code_r) err_nxt = STATUS_BAD_VERSION;
        end
        POS_TYPE: begin
          type_nxt = in_tdata;
          if (err_r == STATUS_OK && in_tdata != data_type_code_r &&
              in_tdata != ack_type_code_r) err_nxt = STATUS_BAD_TYPE;
        end
        [POS_ID_FIRST:POS_ID_LAST]: begin
          if (big_endian_r) id_nxt = {id_r[23:0], in_tdata};
          else id_nxt[{id_lane, 3'b000} +: 8] = id_r[{id_lane, 3'b000} +: 8] | in_tdata;
        end
        POS_FCOUNT: fc_nxt = in_tdata;
        POS_FINDEX: fi_nxt = in_tdata;
        default: begin
          if (big_endian_r) len_nxt = {len_r[7:0], in_tdata};
          else len_nxt[{pos_r[0], 3'b000} +: 8] = len_r[{pos_r[0], 3'b000} +: 8] | in_tdata;
        end
      endcase
    end
  end

  always_comb begin
    if (total < HDR_LEN) status = STATUS_TOO_SHORT;
    else if (err_nxt != STATUS_OK) status = err_nxt;
    else if (len_nxt[15] || total == POS_MAX ||
             CW'(total) != CW'(len_nxt) + CW'(HEADER_BYTES)) status = STATUS_LEN_MISMATCH;
    else status = STATUS_OK;
  end

  always_comb begin
    push_entry.has_pay        = (pos_r >= HDR_LEN) && err_r == STATUS_OK &&
                                type_r != ack_type_code_r && type_r == data_type_code_r;
    push_entry.has_sum        = in_tlast;
    push_entry.pay_byte       = in_tdata;
    push_entry.frame_version  = ver_nxt;
    push_entry.is_ack         = type_nxt == ack_type_code_r;
    push_entry.packet_id      = id_nxt;
    push_entry.frame_count    = fc_nxt;
    push_entry.frame_index    = fi_nxt;
    push_entry.content_length = len_nxt;
    push_entry.status         = status;
    push = accept && (push_entry.has_pay || push_entry.has_sum);
  end

  always_comb begin
    pos_nxt = pos_r;
    if (accept) pos_nxt = in_tlast ? '0 : total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_tlast)) begin
      pos_r  <= '0;
      ver_r  <= '0;
      type_r <= '0;
      id_r   <= '0;
      fc_r   <= '0;
      fi_r   <= '0;
      len_r  <= '0;
      err_r  <= STATUS_OK;
    end else begin
      pos_r  <= pos_nxt;
      ver_r  <= ver_nxt;
      type_r <= type_nxt;
      id_r   <= id_nxt;
      fc_r   <= fc_nxt;
      fi_r   <= fi_nxt;
      len_r  <= len_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ufhp_queue.sv =====
// ----------------------------------------------------------------------------
// ufhp_queue
// short work queue between the parsing front and the result back end
// ----------------------------------------------------------------------------
`default_nettype none

module ufhp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ufhp_pkg::entry_t  push_entry,
  output      logic              full,
  input  wire logic              pop,
  output      logic              head_valid,
  output      ufhp_pkg::entry_t  head
);

  import ufhp_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  entry_t        slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = count_r == NW'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + NW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop) rd_ptr_r <= (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ufhp_back.sv =====
// ----------------------------------------------------------------------------
// ufhp_back
// turns queued entries into payload and summary beats on the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module ufhp_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              head_valid,
  input  wire ufhp_pkg::entry_t                  head,
  output      logic                              pop,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [ufhp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output      logic                              out_tuser,
  output      logic                              out_tlast
);

  import ufhp_pkg::*;

  logic      valid_r, valid_nxt;
  logic      phase_r, phase_nxt;
  out_data_t data_r, data_nxt;
  logic      user_r, user_nxt;
  logic      last_r, last_nxt;
  logic      load;

  assign load = !valid_r || out_tready;

  always_comb begin
    pop       = 1'b0;
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    data_nxt  = data_r;
    user_nxt  = user_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        if (!phase_r && head.has_pay) begin
          data_nxt              = '0;
          data_nxt.payload_byte = head.pay_byte;
          user_nxt              = KIND_PAYLOAD;
          last_nxt              = 1'b0;
          if (head.has_sum) phase_nxt = 1'b1;
          else pop = 1'b1;
        end else begin
          data_nxt                = '0;
          data_nxt.frame_version  = head.frame_version;
          data_nxt.is_ack         = head.is_ack;
          data_nxt.packet_id      = head.packet_id;
          data_nxt.frame_count    = head.frame_count;
          data_nxt.frame_index    = head.frame_index;
          data_nxt.content_length = head.content_length;
          data_nxt.status         = head.status;
          user_nxt                = KIND_SUMMARY;
          last_nxt                = 1'b1;
          phase_nxt               = 1'b0;
          pop                     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// ===== hdl/udp_frame_header_parser_core.sv =====
// an accepted beat goes through the work queue and then the back end's output register
// throughput: one input beat per cycle while the queue is not full; result beats go
// out one per cycle while out_tready is high, so the last byte of a data frame costs
// one extra output beat (payload and summary), which the four-entry work queue absorbs
// reset: rst_n synchronous, active low; clears header state, queue and output valid,
// loads register defaults; no clearing pass
// ----------------------------------------------------------------------------
// udp_frame_header_parser_core
// byte stream datagram header parser with payload pass-through and summary
// ----------------------------------------------------------------------------
`default_nettype none

module udp_frame_header_parser_core #(
  parameter int POSITION_BITS = ufhp_pkg::POSITION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ufhp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [ufhp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [7:0]                        in_tdata,   // data_byte
  input  wire logic                              in_tlast,   // last_byte
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // payload_byte, frame_version, is_ack, packet_id, frame_count, frame_index,
  // content_length, status, zero pad
  output      logic [ufhp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output      logic                              out_tuser,  // kind
  output      logic                              out_tlast   // last_result
);

  import ufhp_pkg::*;

  logic   push, full, pop, head_valid;
  entry_t push_entry, head;

  assign in_tready = !full;

  ufhp_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push       (push),
    .push_entry (push_entry)
  );

  ufhp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ufhp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/ufhp_checker.sv =====
// ----------------------------------------------------------------------------
// ufhp_checker
// port-level checks on the result channel of the header parser
// ----------------------------------------------------------------------------
`default_nettype none

`include "udp_frame_header_parser_core_defines.svh"

module ufhp_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [ufhp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic                              out_tuser,
  input wire logic                              out_tlast
);

  import ufhp_pkg::*;

  out_data_t d;

  assign d = out_data_t'(out_tdata);

  `UFHP_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `UFHP_ASSERT_NEXT(a_hold_data, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
  `UFHP_ASSERT_IMPL(a_payload_clean, clk, rst_n, out_tvalid && out_tuser == KIND_PAYLOAD, !out_tlast && d.frame_version == 8'd0 && d.packet_id == 32'd0 && d.content_length == 16'd0 && d.status == STATUS_OK && d.pad == 4'd0)
  `UFHP_ASSERT_IMPL(a_summary_form, clk, rst_n, out_tvalid && out_tuser == KIND_SUMMARY, out_tlast && d.payload_byte == 8'd0 && d.pad == 4'd0 && d.status <= STATUS_LEN_MISMATCH)
  `UFHP_ASSERT_IMPL(a_ok_length, clk, rst_n, out_tvalid && out_tuser == KIND_SUMMARY && d.status == STATUS_OK, !d.content_length[15])

endmodule

bind udp_frame_header_parser_core ufhp_checker u_ufhp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
